@@ hw/rtl/window3x3_sum_extrema_search_assert.svh @@
// assertion macros used by the checker of the 3x3 window search block
`ifndef WINDOW3X3_SUM_EXTREMA_SEARCH_ASSERT_SVH
`define WINDOW3X3_SUM_EXTREMA_SEARCH_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge
`define WSX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked at every rising clock edge
`define WSX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/wsx_pkg.sv @@
// shared types and constants of the 3x3 window sum extrema search block
package wsx_pkg;

   // configuration port
   localparam int CSR_W       = 7;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   localparam logic [CSR_W-1:0] CSR_COUNT_RESET = 7'd64;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // per-item classification from the front
   typedef struct packed {
      logic window;  // item completes a full 3x3 window
      logic last;    // last sample of the matrix
   } wsx_flags_type;

   localparam int FLAGS_W = $bits(wsx_flags_type);

endpackage

@@ hw/rtl/window3x3_sum_extrema_search.sv @@
// top level of the 3x3 window sum extrema search block
//
// Samples of a matrix enter on the req channel one item at a time, in raster
// order, with req_valid / req_stall. The csr port sets the row count (index 0)
// and the column count (index 1); both reset to 64, a zero is taken as one and
// a value above the maximum is taken as the maximum. Write them only while the
// block is idle.
// After the last sample of a matrix the rsp channel gives one item: whether any
// full 3x3 window existed, and the greatest and least window sums with the
// top-left row and column of each (earliest window in raster order on a tie).
// Throughput is one sample per cycle while req_stall is low: the front pipeline
// and the line store (one read and one write port) handle a sample every cycle.
// The result passes stage a, stage b, the queue and the result register to rsp_valid.
// While rsp_stall holds a result, the next last item waits in the queue, the queue
// and pipeline fill behind it and req_stall rises once four items are in flight.
// Synchronous reset clears positions, the queue and the search state and sets
// the counts to 64; the line store keeps whatever it held.
module window3x3_sum_extrema_search import wsx_pkg::*; #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_found,
   output logic signed [SAMPLE_BITS+3:0]           rsp_largest_sum,
   output logic [$clog2(MAX_ROWS)-1:0]             rsp_largest_row,
   output logic [$clog2(MAX_COLUMNS)-1:0]          rsp_largest_column,
   output logic signed [SAMPLE_BITS+3:0]           rsp_smallest_sum,
   output logic [$clog2(MAX_ROWS)-1:0]             rsp_smallest_row,
   output logic [$clog2(MAX_COLUMNS)-1:0]          rsp_smallest_column,
   input  logic                                    csr_write,
   input  logic [CSR_INDEX_W-1:0]                  csr_index,
   input  logic [CSR_W-1:0]                        csr_data
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int SUM_W  = SAMPLE_BITS + 4;
   localparam int ITEM_W = SUM_W + ROW_W + COL_W + FLAGS_W;

   logic [CSR_W-1:0]        row_count_ff, column_count_ff;
   logic [QCOUNT_W-1:0]     queue_count;
   logic                    push, pop, q_valid;
   logic signed [SUM_W-1:0] push_sum;
   logic [ROW_W-1:0]        push_row;
   logic [COL_W-1:0]        push_column;
   wsx_flags_type           push_flags;
   logic [ITEM_W-1:0]       q_data;
   logic signed [SUM_W-1:0] q_sum;
   logic [ROW_W-1:0]        q_row;
   logic [COL_W-1:0]        q_column;
   wsx_flags_type           q_flags;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= CSR_COUNT_RESET;
         column_count_ff <= CSR_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               row_count_ff <= csr_data;
            end
            CSR_COLUMN_COUNT: begin
               column_count_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // front: positions, line store and window sums
   wsx_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ROW_W       (ROW_W),
      .COL_W       (COL_W),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .row_count    (row_count_ff),
      .column_count (column_count_ff),
      .queue_count  (queue_count),
      .push         (push),
      .push_sum     (push_sum),
      .push_row     (push_row),
      .push_column  (push_column),
      .push_flags   (push_flags)
   );

   // queue between front and back
   wsx_queue #(
      .DATA_W (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_flags, push_row, push_column, push_sum}),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .count     (queue_count)
   );

   assign {q_flags, q_row, q_column, q_sum} = q_data;

   // back: extrema search and result register
   wsx_back #(
      .ROW_W (ROW_W),
      .COL_W (COL_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_sum               (q_sum),
      .q_row               (q_row),
      .q_column            (q_column),
      .q_flags             (q_flags),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_largest_sum     (rsp_largest_sum),
      .rsp_largest_row     (rsp_largest_row),
      .rsp_largest_column  (rsp_largest_column),
      .rsp_smallest_sum    (rsp_smallest_sum),
      .rsp_smallest_row    (rsp_smallest_row),
      .rsp_smallest_column (rsp_smallest_column)
   );

endmodule

@@ hw/rtl/wsx_queue.sv @@
// small register queue that decouples the front from the back
module wsx_queue import wsx_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [DATA_W-1:0]   push_data,
   input  logic                pop,
   output logic                pop_valid,
   output logic [DATA_W-1:0]   pop_data,
   output logic [QCOUNT_W-1:0] count
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [DATA_W-1:0]   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/wsx_front.sv @@
// front: raster position tracking, line store, column sums and window sum
module wsx_front import wsx_pkg::*; #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int ROW_W       = $clog2(MAX_ROWS),
   parameter int COL_W       = $clog2(MAX_COLUMNS),
   parameter int SUM_W       = SAMPLE_BITS + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic [CSR_W-1:0]              row_count,
   input  logic [CSR_W-1:0]              column_count,
   input  logic [QCOUNT_W-1:0]           queue_count,
   output logic                          push,
   output logic signed [SUM_W-1:0]       push_sum,
   output logic [ROW_W-1:0]              push_row,
   output logic [COL_W-1:0]              push_column,
   output wsx_flags_type                 push_flags
);

   localparam int CS_W  = SAMPLE_BITS + 2;
   localparam int RCN_W = ($clog2(MAX_ROWS + 1) > CSR_W) ? $clog2(MAX_ROWS + 1) : CSR_W;
   localparam int CCN_W = ($clog2(MAX_COLUMNS + 1) > CSR_W) ?
                          $clog2(MAX_COLUMNS + 1) : CSR_W;
   localparam int OCC_W = QCOUNT_W + 1;

   // line store: upper row in the high half, lower row in the low half
   logic [2*SAMPLE_BITS-1:0] line_mem [MAX_COLUMNS];

   logic [ROW_W-1:0]         row_pos_ff, row_pos_in;
   logic [COL_W-1:0]         col_pos_ff, col_pos_in;
   logic [RCN_W-1:0]         rows_lim;
   logic [CCN_W-1:0]         cols_lim;
   logic                     col_end, row_end, accept;
   logic [OCC_W-1:0]         occupancy;

   logic                     a_valid_ff;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic [COL_W-1:0]         a_addr_ff;
   wsx_flags_type            a_flags_ff;
   logic [ROW_W-1:0]         a_row_ff;
   logic [COL_W-1:0]         a_col_ff;
   logic [2*SAMPLE_BITS-1:0] rd_data_ff;
   logic                     byp_ff;
   logic [2*SAMPLE_BITS-1:0] byp_data_ff;
   logic [2*SAMPLE_BITS-1:0] pair;
   logic signed [SAMPLE_BITS-1:0] upper, lower;
   logic signed [CS_W-1:0]   col_sum;
   logic [2*SAMPLE_BITS-1:0] wr_data;

   logic signed [CS_W-1:0]   cw_ff [3];
   logic                     b_valid_ff;
   wsx_flags_type            b_flags_ff;
   logic [ROW_W-1:0]         b_row_ff;
   logic [COL_W-1:0]         b_col_ff;

   // clamp the configured counts to 1..max
   always_comb begin
      if (row_count == '0) begin
         rows_lim = RCN_W'(1);
      end else if (RCN_W'(row_count) > RCN_W'(MAX_ROWS)) begin
         rows_lim = RCN_W'(MAX_ROWS);
      end else begin
         rows_lim = RCN_W'(row_count);
      end
      if (column_count == '0) begin
         cols_lim = CCN_W'(1);
      end else if (CCN_W'(column_count) > CCN_W'(MAX_COLUMNS)) begin
         cols_lim = CCN_W'(MAX_COLUMNS);
      end else begin
         cols_lim = CCN_W'(column_count);
      end
   end

   // hold off new items while queue plus pipeline could overflow
   assign occupancy = OCC_W'(queue_count) + OCC_W'(a_valid_ff) + OCC_W'(b_valid_ff);
   assign req_stall = (occupancy >= OCC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // raster position
   assign col_end = (CCN_W'(col_pos_ff) + CCN_W'(1)) >= cols_lim;
   assign row_end = (RCN_W'(row_pos_ff) + RCN_W'(1)) >= rows_lim;

   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (col_end) begin
         col_pos_in = '0;
         row_pos_in = row_end ? '0 : row_pos_ff + ROW_W'(1);
      end else begin
         col_pos_in = col_pos_ff + COL_W'(1);
      end
   end

   // stage a: column sum from the line store read
   assign pair    = byp_ff ? byp_data_ff : rd_data_ff;
   assign upper   = pair[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign lower   = pair[SAMPLE_BITS-1:0];
   assign col_sum = CS_W'(upper) + CS_W'(lower) + CS_W'(a_sample_ff);
   assign wr_data = {lower, a_sample_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         byp_ff     <= 1'b0;
      end else begin
         if (accept) begin
            row_pos_ff <= row_pos_in;
            col_pos_ff <= col_pos_in;
         end
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         byp_ff     <= a_valid_ff && (a_addr_ff == col_pos_ff);
      end
   end

   // payload registers of both stages
   always_ff @(posedge clock) begin
      byp_data_ff <= wr_data;
      if (accept) begin
         a_sample_ff       <= req_sample;
         a_addr_ff         <= col_pos_ff;
         a_flags_ff.window <= (row_pos_ff >= ROW_W'(2)) && (col_pos_ff >= COL_W'(2));
         a_flags_ff.last   <= col_end && row_end;
         a_row_ff          <= row_pos_ff - ROW_W'(2);
         a_col_ff          <= col_pos_ff - COL_W'(2);
      end
      if (a_valid_ff) begin
         cw_ff[0]   <= cw_ff[1];
         cw_ff[1]   <= cw_ff[2];
         cw_ff[2]   <= col_sum;
         b_flags_ff <= a_flags_ff;
         b_row_ff   <= a_row_ff;
         b_col_ff   <= a_col_ff;
      end
   end

   // line store: read at the current column, write back the shifted pair
   always_ff @(posedge clock) begin
      rd_data_ff <= line_mem[col_pos_ff];
      if (a_valid_ff) begin
         line_mem[a_addr_ff] <= wr_data;
      end
   end

   // stage b: window sum into the queue
   assign push        = b_valid_ff;
   assign push_sum    = SUM_W'(cw_ff[0]) + SUM_W'(cw_ff[1]) + SUM_W'(cw_ff[2]);
   assign push_row    = b_row_ff;
   assign push_column = b_col_ff;
   assign push_flags  = b_flags_ff;

endmodule

@@ hw/rtl/wsx_back.sv @@
// back: largest and smallest window search and the result register
module wsx_back import wsx_pkg::*; #(
   parameter int ROW_W = 6,
   parameter int COL_W = 6,
   parameter int SUM_W = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  logic signed [SUM_W-1:0] q_sum,
   input  logic [ROW_W-1:0]        q_row,
   input  logic [COL_W-1:0]        q_column,
   input  wsx_flags_type           q_flags,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_found,
   output logic signed [SUM_W-1:0] rsp_largest_sum,
   output logic [ROW_W-1:0]        rsp_largest_row,
   output logic [COL_W-1:0]        rsp_largest_column,
   output logic signed [SUM_W-1:0] rsp_smallest_sum,
   output logic [ROW_W-1:0]        rsp_smallest_row,
   output logic [COL_W-1:0]        rsp_smallest_column
);

   logic                    have_ff, have_in;
   logic signed [SUM_W-1:0] hi_sum_ff, hi_sum_in, lo_sum_ff, lo_sum_in;
   logic [ROW_W-1:0]        hi_row_ff, hi_row_in, lo_row_ff, lo_row_in;
   logic [COL_W-1:0]        hi_col_ff, hi_col_in, lo_col_ff, lo_col_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    take;

   // a last item waits while an earlier result is still held
   assign take = q_valid && (!q_flags.last || !rsp_valid_ff || !rsp_stall);
   assign pop  = take;

   // result stays while stalled, a new one loads with the last item
   assign rsp_valid_in = (take && q_flags.last) || (rsp_valid_ff && rsp_stall);

   // compare the incoming window against the best so far
   always_comb begin
      have_in   = have_ff;
      hi_sum_in = hi_sum_ff;
      hi_row_in = hi_row_ff;
      hi_col_in = hi_col_ff;
      lo_sum_in = lo_sum_ff;
      lo_row_in = lo_row_ff;
      lo_col_in = lo_col_ff;
      if (q_flags.window) begin
         have_in = 1'b1;
         if (!have_ff || (q_sum > hi_sum_ff)) begin
            hi_sum_in = q_sum;
            hi_row_in = q_row;
            hi_col_in = q_column;
         end
         if (!have_ff || (q_sum < lo_sum_ff)) begin
            lo_sum_in = q_sum;
            lo_row_in = q_row;
            lo_col_in = q_column;
         end
      end
   end

   // search state, cleared at the end of every matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         hi_sum_ff    <= '0;
         hi_row_ff    <= '0;
         hi_col_ff    <= '0;
         lo_sum_ff    <= '0;
         lo_row_ff    <= '0;
         lo_col_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            if (q_flags.last) begin
               have_ff      <= 1'b0;
               hi_sum_ff    <= '0;
               hi_row_ff    <= '0;
               hi_col_ff    <= '0;
               lo_sum_ff    <= '0;
               lo_row_ff    <= '0;
               lo_col_ff    <= '0;
            end else begin
               have_ff   <= have_in;
               hi_sum_ff <= hi_sum_in;
               hi_row_ff <= hi_row_in;
               hi_col_ff <= hi_col_in;
               lo_sum_ff <= lo_sum_in;
               lo_row_ff <= lo_row_in;
               lo_col_ff <= lo_col_in;
            end
         end
      end
   end

   // result payload, loaded with the last item of a matrix
   always_ff @(posedge clock) begin
      if (take && q_flags.last) begin
         rsp_found           <= have_in;
         rsp_largest_sum     <= hi_sum_in;
         rsp_largest_row     <= hi_row_in;
         rsp_largest_column  <= hi_col_in;
         rsp_smallest_sum    <= lo_sum_in;
         rsp_smallest_row    <= lo_row_in;
         rsp_smallest_column <= lo_col_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/wsx_checker.sv @@
// port-level checker of the 3x3 window search block and its bind
`include "window3x3_sum_extrema_search_assert.svh"

module wsx_checker import wsx_pkg::*; #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64,
   parameter int SAMPLE_BITS = 16
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic signed [SAMPLE_BITS-1:0]           req_sample,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic                                    rsp_found,
   input logic signed [SAMPLE_BITS+3:0]           rsp_largest_sum,
   input logic [$clog2(MAX_ROWS)-1:0]             rsp_largest_row,
   input logic [$clog2(MAX_COLUMNS)-1:0]          rsp_largest_column,
   input logic signed [SAMPLE_BITS+3:0]           rsp_smallest_sum,
   input logic [$clog2(MAX_ROWS)-1:0]             rsp_smallest_row,
   input logic [$clog2(MAX_COLUMNS)-1:0]          rsp_smallest_column,
   input logic                                    csr_write,
   input logic [CSR_INDEX_W-1:0]                  csr_index,
   input logic [CSR_W-1:0]                        csr_data
);

   // a stalled result stays and holds its found flag and both sums
   `WSX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_largest_sum) && $stable(rsp_smallest_sum))

   // a matrix without a window reports all zeros
   `WSX_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && !rsp_found, (rsp_largest_sum == '0) && (rsp_smallest_sum == '0) && (rsp_largest_row == '0) && (rsp_largest_column == '0) && (rsp_smallest_row == '0) && (rsp_smallest_column == '0))

   // the largest window sum never lies below the smallest
   `WSX_ASSERT_NOW(a_extrema_order, clock, reset, rsp_valid && rsp_found, rsp_largest_sum >= rsp_smallest_sum)

   // after reset nothing is pending and the input is open
   `WSX_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind window3x3_sum_extrema_search wsx_checker #(
   .MAX_ROWS    (MAX_ROWS),
   .MAX_COLUMNS (MAX_COLUMNS),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_wsx_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_sample          (req_sample),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_found           (rsp_found),
   .rsp_largest_sum     (rsp_largest_sum),
   .rsp_largest_row     (rsp_largest_row),
   .rsp_largest_column  (rsp_largest_column),
   .rsp_smallest_sum    (rsp_smallest_sum),
   .rsp_smallest_row    (rsp_smallest_row),
   .rsp_smallest_column (rsp_smallest_column),
   .csr_write           (csr_write),
   .csr_index           (csr_index),
   .csr_data            (csr_data)
);
